[src/scl_pkg.sv]
// Lexer package: token kinds, scan modes, keyword table.
`timescale 1ns / 1ps
package scl_pkg;

   localparam int NUM_KW = 34;
   localparam int KW_MAX_LEN = 14;

   localparam logic [6:0] K_IDENT  = 7'd34;
   localparam logic [6:0] K_NUMBER = 7'd35;
   localparam logic [6:0] K_SEMI   = 7'd36;
   localparam logic [6:0] K_LPAREN = 7'd37;
   localparam logic [6:0] K_RPAREN = 7'd38;
   localparam logic [6:0] K_LBRACE = 7'd39;
   localparam logic [6:0] K_RBRACE = 7'd40;
   localparam logic [6:0] K_LBRACK = 7'd41;
   localparam logic [6:0] K_RBRACK = 7'd42;
   localparam logic [6:0] K_COLON  = 7'd43;
   localparam logic [6:0] K_DOT    = 7'd44;
   localparam logic [6:0] K_QUEST  = 7'd45;
   localparam logic [6:0] K_COMMA  = 7'd46;
   localparam logic [6:0] K_EQEQ   = 7'd47;
   localparam logic [6:0] K_EQ     = 7'd48;
   localparam logic [6:0] K_PLUSEQ = 7'd49;
   localparam logic [6:0] K_INC    = 7'd50;
   localparam logic [6:0] K_PLUS   = 7'd51;
   localparam logic [6:0] K_DEC    = 7'd52;
   localparam logic [6:0] K_MINUSEQ= 7'd53;
   localparam logic [6:0] K_MINUS  = 7'd54;
   localparam logic [6:0] K_SHREQ  = 7'd55;
   localparam logic [6:0] K_SHR    = 7'd56;
   localparam logic [6:0] K_GE     = 7'd57;
   localparam logic [6:0] K_GT     = 7'd58;
   localparam logic [6:0] K_SHLEQ  = 7'd59;
   localparam logic [6:0] K_SHL    = 7'd60;
   localparam logic [6:0] K_LE     = 7'd61;
   localparam logic [6:0] K_LT     = 7'd62;
   localparam logic [6:0] K_STAREQ = 7'd63;
   localparam logic [6:0] K_STAR   = 7'd64;
   localparam logic [6:0] K_SLASHEQ= 7'd65;
   localparam logic [6:0] K_SLASH  = 7'd66;
   localparam logic [6:0] K_ANDAND = 7'd67;
   localparam logic [6:0] K_ANDEQ  = 7'd68;
   localparam logic [6:0] K_AMP    = 7'd69;
   localparam logic [6:0] K_OROR   = 7'd70;
   localparam logic [6:0] K_OREQ   = 7'd71;
   localparam logic [6:0] K_PIPE   = 7'd72;
   localparam logic [6:0] K_PCTEQ  = 7'd73;
   localparam logic [6:0] K_PCT    = 7'd74;
   localparam logic [6:0] K_UNDEF  = 7'd75;
   localparam logic [6:0] K_EOF    = 7'd76;

   typedef enum logic [14:0] {
      M_IDLE  = 15'b000000000000001,
      M_IDENT = 15'b000000000000010,
      M_NUM   = 15'b000000000000100,
      M_EQ    = 15'b000000000001000,
      M_PLUS  = 15'b000000000010000,
      M_MINUS = 15'b000000000100000,
      M_GT    = 15'b000000001000000,
      M_GTGT  = 15'b000000010000000,
      M_LT    = 15'b000000100000000,
      M_LTLT  = 15'b000001000000000,
      M_STAR  = 15'b000010000000000,
      M_SLASH = 15'b000100000000000,
      M_AMP   = 15'b001000000000000,
      M_PIPE  = 15'b010000000000000,
      M_PCT   = 15'b100000000000000
   } mode_type;

   typedef struct packed {
      logic [6:0]  kind;
      logic [15:0] line;
      logic [15:0] col;
      logic [31:0] offset;
      logic [7:0]  length;
   } token_type;

   // keyword text, first character in the low byte
   function automatic logic [8*KW_MAX_LEN-1:0] kw_text(input int k);
      logic [8*KW_MAX_LEN-1:0] t;
      string s;
      unique case (k)
         0: s = "int";       1: s = "int8";      2: s = "int16";
         3: s = "int32";     4: s = "int64";     5: s = "uint8";
         6: s = "uint16";    7: s = "uint32";    8: s = "uint64";
         9: s = "bool";      10: s = "true";     11: s = "false";
         12: s = "float";    13: s = "double";   14: s = "char";
         15: s = "utf8char"; 16: s = "utf16char"; 17: s = "void";
         18: s = "if";       19: s = "do";       20: s = "for";
         21: s = "big";      22: s = "continue"; 23: s = "return";
         24: s = "break";    25: s = "while";    26: s = "switch";
         27: s = "case";     28: s = "small";    29: s = "enum";
         30: s = "typedefinition"; 31: s = "else"; 32: s = "struct";
         default: s = "static";
      endcase
      t = '0;
      for (int i = 0; i < KW_MAX_LEN; i++) begin
         if (i < s.len()) t[8*i +: 8] = s[i];
      end
      return t;
   endfunction

   function automatic logic [3:0] kw_len(input int k);
      unique case (k)
         0, 20, 21: return 4'd3;
         1, 9, 10, 14, 17, 27, 29, 31: return 4'd4;
         2, 3, 4, 5, 11, 12, 24, 25, 28: return 4'd5;
         6, 7, 8, 13, 23, 26, 32, 33: return 4'd6;
         15, 22: return 4'd8;
         16: return 4'd9;
         18, 19: return 4'd2;
         default: return 4'd14;
      endcase
   endfunction

endpackage

[src/scl_kw_match.sv]
// Keyword candidate narrowing and final keyword pick.
`timescale 1ns / 1ps
module scl_kw_match #(
   parameter int LEN_W = 8
) (
   input  logic [scl_pkg::NUM_KW-1:0] cand,
   input  logic [LEN_W-1:0]           pos,
   input  logic [7:0]                 ch,
   output logic [scl_pkg::NUM_KW-1:0] cand_next,
   output logic [6:0]                 kind
);
   always_comb begin
      for (int k = 0; k < scl_pkg::NUM_KW; k++) begin
         logic [8*scl_pkg::KW_MAX_LEN-1:0] t;
         logic [7:0] b;
         t = scl_pkg::kw_text(k);
         b = 8'd0;
         for (int i = 0; i < scl_pkg::KW_MAX_LEN; i++) begin
            if (pos == LEN_W'(i)) b = t[8*i +: 8];
         end
         cand_next[k] = cand[k] && (pos < LEN_W'(scl_pkg::kw_len(k))) && (b == ch);
      end
   end

   // first surviving keyword whose length equals the pending length
   always_comb begin
      kind = scl_pkg::K_IDENT;
      for (int k = scl_pkg::NUM_KW - 1; k >= 0; k--) begin
         if (cand[k] && pos == LEN_W'(scl_pkg::kw_len(k))) kind = 7'(k);
      end
   end
endmodule

[src/source_code_lexer.sv]
// Top level of the source lexer: byte scanner, token formation and result queue.
// Output: the req_ beat that completes a token writes it into the output queue, and it leaves on rsp_ from there.
// Throughput: one req_ beat per cycle while rsp_ready is high; a beat that gives two
//   tokens holds off req_ while they drain through a two-entry queue (req_ready is low
//   with two entries held, or with one held and rsp_ready low).
// Reset: synchronous, active high; clears mode, counters (line/col 1) and queue.
`timescale 1ns / 1ps
module source_code_lexer #(
   parameter int MAX_TOKEN_LEN = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_token_kind,
   output logic [15:0] rsp_start_line,
   output logic [15:0] rsp_start_col,
   output logic [31:0] rsp_start_offset,
   output logic [7:0]  rsp_token_length,
   output logic        rsp_last_of_run
);
   localparam int CAP_I = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
   localparam logic [7:0] CAP = 8'(CAP_I);

   // lexer state
   scl_pkg::mode_type mode_ff, mode_in;
   logic        dot_ff, dot_in;
   logic [scl_pkg::NUM_KW-1:0] cand_ff, cand_in;
   logic [7:0]  plen_ff, plen_in;
   logic [15:0] pline_ff, pline_in, pcol_ff, pcol_in;
   logic [31:0] poff_ff, poff_in;
   logic [15:0] line_ff, line_in, col_ff, col_in;
   logic [31:0] off_ff, off_in;

   // output queue, two entries
   scl_pkg::token_type q_tok_ff [2];
   logic       q_last_ff [2];
   logic [1:0] q_cnt_ff;
   logic       q_rd_ff;

   logic accept, pop;
   assign req_ready = (q_cnt_ff == 2'd0) || (q_cnt_ff == 2'd1 && rsp_ready);
   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;

   // keyword unit: a pending identifier narrows its own mask; any other mode can
   // only start a fresh identifier, which narrows all ones at position zero
   logic fresh_ident;
   logic [scl_pkg::NUM_KW-1:0] kw_cand_src, kw_cand_nx;
   logic [7:0] kw_pos;
   logic [6:0] kw_kind_unused, close_kw_kind, dummy_nx_unused;
   logic [scl_pkg::NUM_KW-1:0] close_cand_unused;
   assign fresh_ident = mode_ff != scl_pkg::M_IDENT;
   assign kw_cand_src = fresh_ident ? '1 : cand_ff;
   assign kw_pos      = fresh_ident ? 8'd0 : plen_ff;

   scl_kw_match #(.LEN_W(8)) u_narrow (
      .cand(kw_cand_src), .pos(kw_pos), .ch(req_ch),
      .cand_next(kw_cand_nx), .kind(kw_kind_unused)
   );
   // a saturated identifier never matches: pos 255 exceeds every keyword length
   scl_kw_match #(.LEN_W(8)) u_close (
      .cand(cand_ff), .pos(plen_ff), .ch(8'd0),
      .cand_next(close_cand_unused), .kind(close_kw_kind)
   );
   assign dummy_nx_unused = kw_kind_unused;

   // byte classes
   logic c_alpha, c_digit, c_blank;
   logic [7:0] c;
   assign c       = req_ch;
   assign c_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   assign c_digit = c >= "0" && c <= "9";
   assign c_blank = c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;

   logic [7:0] plen_inc;
   assign plen_inc = (plen_ff < CAP) ? plen_ff + 8'd1 : plen_ff;

   scl_pkg::token_type t0, t1, pend_tok, cur_tok;
   logic n0, n1;

   function automatic logic [6:0] short_kind(input scl_pkg::mode_type m);
      unique case (m)
         scl_pkg::M_EQ:    return scl_pkg::K_EQ;
         scl_pkg::M_PLUS:  return scl_pkg::K_PLUS;
         scl_pkg::M_MINUS: return scl_pkg::K_MINUS;
         scl_pkg::M_GT:    return scl_pkg::K_GT;
         scl_pkg::M_GTGT:  return scl_pkg::K_SHR;
         scl_pkg::M_LT:    return scl_pkg::K_LT;
         scl_pkg::M_LTLT:  return scl_pkg::K_SHL;
         scl_pkg::M_STAR:  return scl_pkg::K_STAR;
         scl_pkg::M_SLASH: return scl_pkg::K_SLASH;
         scl_pkg::M_AMP:   return scl_pkg::K_AMP;
         scl_pkg::M_PIPE:  return scl_pkg::K_PIPE;
         scl_pkg::M_PCT:   return scl_pkg::K_PCT;
         default:          return scl_pkg::K_UNDEF;
      endcase
   endfunction

   function automatic logic [6:0] op_complete(input scl_pkg::mode_type m,
                                              input logic [7:0] b);
      unique case (m)
         scl_pkg::M_EQ:    return b == "=" ? scl_pkg::K_EQEQ : 7'd0;
         scl_pkg::M_PLUS:  return b == "=" ? scl_pkg::K_PLUSEQ :
                                  (b == "+" ? scl_pkg::K_INC : 7'd0);
         scl_pkg::M_MINUS: return b == "-" ? scl_pkg::K_DEC :
                                  (b == "=" ? scl_pkg::K_MINUSEQ : 7'd0);
         scl_pkg::M_GT:    return b == "=" ? scl_pkg::K_GE : 7'd0;
         scl_pkg::M_GTGT:  return b == "=" ? scl_pkg::K_SHREQ : 7'd0;
         scl_pkg::M_LT:    return b == "=" ? scl_pkg::K_LE : 7'd0;
         scl_pkg::M_LTLT:  return b == "=" ? scl_pkg::K_SHLEQ : 7'd0;
         scl_pkg::M_STAR:  return b == "=" ? scl_pkg::K_STAREQ : 7'd0;
         scl_pkg::M_SLASH: return b == "=" ? scl_pkg::K_SLASHEQ : 7'd0;
         scl_pkg::M_AMP:   return b == "&" ? scl_pkg::K_ANDAND :
                                  (b == "=" ? scl_pkg::K_ANDEQ : 7'd0);
         scl_pkg::M_PIPE:  return b == "|" ? scl_pkg::K_OROR :
                                  (b == "=" ? scl_pkg::K_OREQ : 7'd0);
         scl_pkg::M_PCT:   return b == "=" ? scl_pkg::K_PCTEQ : 7'd0;
         default:          return 7'd0;
      endcase
   endfunction

   // token that the pending state closes to (valid unless idle)
   always_comb begin
      pend_tok.line   = pline_ff;
      pend_tok.col    = pcol_ff;
      pend_tok.offset = poff_ff;
      pend_tok.length = 8'd1;
      pend_tok.kind   = short_kind(mode_ff);
      if (mode_ff == scl_pkg::M_IDENT) begin
         pend_tok.kind = close_kw_kind;
         pend_tok.length = plen_ff;
      end else if (mode_ff == scl_pkg::M_NUM) begin
         pend_tok.kind = scl_pkg::K_NUMBER;
         pend_tok.length = plen_ff;
      end else if (mode_ff == scl_pkg::M_GTGT || mode_ff == scl_pkg::M_LTLT) begin
         pend_tok.length = 8'd2;
      end
      cur_tok.line   = line_ff;
      cur_tok.col    = col_ff;
      cur_tok.offset = off_ff;
      cur_tok.length = 8'd1;
      cur_tok.kind   = scl_pkg::K_UNDEF;
   end

   // main scan step
   always_comb begin
      logic cont;
      logic [6:0] ok;
      mode_in  = mode_ff;  dot_in  = dot_ff;  cand_in = cand_ff;
      plen_in  = plen_ff;  pline_in = pline_ff; pcol_in = pcol_ff; poff_in = poff_ff;
      line_in  = line_ff;  col_in  = col_ff;  off_in  = off_ff;
      t0 = pend_tok; t1 = cur_tok; n0 = 1'b0; n1 = 1'b0;
      cont = 1'b0;
      ok = op_complete(mode_ff, c);
      if (req_end_of_source) begin
         n0 = mode_ff != scl_pkg::M_IDLE;
         t1 = cur_tok;
         t1.kind = scl_pkg::K_EOF;
         t1.length = 8'd3;
         n1 = 1'b1;
         mode_in = scl_pkg::M_IDLE; dot_in = 1'b0; cand_in = '1; plen_in = 8'd0;
         pline_in = 16'd1; pcol_in = 16'd1; poff_in = 32'd0;
         line_in = 16'd1; col_in = 16'd1; off_in = 32'd0;
      end else begin
         off_in = (off_ff != '1) ? off_ff + 32'd1 : off_ff;
         if (c == 8'h0A) begin
            line_in = (line_ff != '1) ? line_ff + 16'd1 : line_ff;
            col_in = 16'd1;
         end else begin
            col_in = (col_ff != '1) ? col_ff + 16'd1 : col_ff;
         end
         priority if (mode_ff == scl_pkg::M_IDENT && (c_alpha || c_digit)) begin
            cand_in = kw_cand_nx; plen_in = plen_inc; cont = 1'b1;
         end else if (mode_ff == scl_pkg::M_NUM &&
                      (c_digit || (c == "." && !dot_ff))) begin
            if (c == ".") dot_in = 1'b1;
            plen_in = plen_inc; cont = 1'b1;
         end else if (mode_ff == scl_pkg::M_NUM && c == "f") begin
            t0.kind = scl_pkg::K_NUMBER; t0.length = plen_inc; n0 = 1'b1;
            mode_in = scl_pkg::M_IDLE; plen_in = plen_inc; cont = 1'b1;
         end else if (mode_ff == scl_pkg::M_GT && c == ">") begin
            mode_in = scl_pkg::M_GTGT; cont = 1'b1;
         end else if (mode_ff == scl_pkg::M_LT && c == "<") begin
            mode_in = scl_pkg::M_LTLT; cont = 1'b1;
         end else if (ok != 7'd0) begin
            t0.kind = ok;
            t0.length = (mode_ff == scl_pkg::M_GTGT || mode_ff == scl_pkg::M_LTLT)
                        ? 8'd3 : 8'd2;
            n0 = 1'b1; mode_in = scl_pkg::M_IDLE; cont = 1'b1;
         end else begin
            cont = 1'b0;
         end
         if (!cont) begin
            // close what is pending, then lex c fresh
            n0 = mode_ff != scl_pkg::M_IDLE;
            mode_in = scl_pkg::M_IDLE;
            if (!c_blank) begin
               priority if (c_alpha) begin
                  cand_in = kw_cand_nx; mode_in = scl_pkg::M_IDENT;
               end else if (c_digit) begin
                  dot_in = 1'b0; mode_in = scl_pkg::M_NUM;
               end else begin
                  unique case (c)
                     "=": mode_in = scl_pkg::M_EQ;
                     "+": mode_in = scl_pkg::M_PLUS;
                     "-": mode_in = scl_pkg::M_MINUS;
                     ">": mode_in = scl_pkg::M_GT;
                     "<": mode_in = scl_pkg::M_LT;
                     "*": mode_in = scl_pkg::M_STAR;
                     "/": mode_in = scl_pkg::M_SLASH;
                     "&": mode_in = scl_pkg::M_AMP;
                     "|": mode_in = scl_pkg::M_PIPE;
                     "%": mode_in = scl_pkg::M_PCT;
                     ";": begin n1 = 1'b1; t1.kind = scl_pkg::K_SEMI; end
                     "(": begin n1 = 1'b1; t1.kind = scl_pkg::K_LPAREN; end
                     ")": begin n1 = 1'b1; t1.kind = scl_pkg::K_RPAREN; end
                     "{": begin n1 = 1'b1; t1.kind = scl_pkg::K_LBRACE; end
                     "}": begin n1 = 1'b1; t1.kind = scl_pkg::K_RBRACE; end
                     "[": begin n1 = 1'b1; t1.kind = scl_pkg::K_LBRACK; end
                     "]": begin n1 = 1'b1; t1.kind = scl_pkg::K_RBRACK; end
                     ":": begin n1 = 1'b1; t1.kind = scl_pkg::K_COLON; end
                     ".": begin n1 = 1'b1; t1.kind = scl_pkg::K_DOT; end
                     "?": begin n1 = 1'b1; t1.kind = scl_pkg::K_QUEST; end
                     ",": begin n1 = 1'b1; t1.kind = scl_pkg::K_COMMA; end
                     default: begin n1 = 1'b1; t1.kind = scl_pkg::K_UNDEF; end
                  endcase
               end
               if (!n1) begin
                  // a new token begins here
                  pline_in = line_ff; pcol_in = col_ff; poff_in = off_ff;
                  plen_in = 8'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= scl_pkg::M_IDLE; dot_ff <= 1'b0; cand_ff <= '1; plen_ff <= 8'd0;
         pline_ff <= 16'd1; pcol_ff <= 16'd1; poff_ff <= 32'd0;
         line_ff <= 16'd1; col_ff <= 16'd1; off_ff <= 32'd0;
      end else if (accept) begin
         mode_ff <= mode_in; dot_ff <= dot_in; cand_ff <= cand_in; plen_ff <= plen_in;
         pline_ff <= pline_in; pcol_ff <= pcol_in; poff_ff <= poff_in;
         line_ff <= line_in; col_ff <= col_in; off_ff <= off_in;
      end
   end

   // output queue: a beat is only accepted when both entries are free after pop
   logic [1:0] push_n;
   assign push_n = accept ? {1'b0, n0} + {1'b0, n1} : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= 2'd0;
         q_rd_ff  <= 1'b0;
      end else begin
         q_cnt_ff <= q_cnt_ff - {1'b0, pop} + push_n;
         if (pop) q_rd_ff <= ~q_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic wp;
      wp = q_rd_ff ^ (q_cnt_ff == 2'd1 && !pop);
      if (pop && q_cnt_ff == 2'd1) wp = ~q_rd_ff;
      if (accept) begin
         if (n0) begin
            q_tok_ff[wp] <= t0;
            q_last_ff[wp] <= !n1;
            if (n1) begin
               q_tok_ff[~wp] <= t1;
               q_last_ff[~wp] <= 1'b1;
            end
         end else if (n1) begin
            q_tok_ff[wp] <= t1;
            q_last_ff[wp] <= 1'b1;
         end
      end
   end

   assign rsp_valid        = q_cnt_ff != 2'd0;
   assign rsp_token_kind   = q_tok_ff[q_rd_ff].kind;
   assign rsp_start_line   = q_tok_ff[q_rd_ff].line;
   assign rsp_start_col    = q_tok_ff[q_rd_ff].col;
   assign rsp_start_offset = q_tok_ff[q_rd_ff].offset;
   assign rsp_token_length = q_tok_ff[q_rd_ff].length;
   assign rsp_last_of_run  = q_last_ff[q_rd_ff];

   // queue never overfills
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff != 2'd3) else $error("output queue overflow");
   // end of source always produces a token the next cycle
   a_eof_out: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_source |=> rsp_valid) else $error("eof lost");
   // counters back to start after end of source
   a_eof_rst: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_source |=> line_ff == 16'd1 && off_ff == 32'd0)
      else $error("counters not cleared");
endmodule

[sim/tb_top.sv]
// Self-checking testbench for source_code_lexer: directed table plus random source text.
`timescale 1ns / 1ps
module tb_top;

   // keyword kind used in the directed table
   localparam logic [6:0] KW_IF = 7'd18;
   localparam int WATCHDOG_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_ch = 8'h00;
   logic        req_end_of_source = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [6:0]  rsp_token_kind;
   logic [15:0] rsp_start_line;
   logic [15:0] rsp_start_col;
   logic [31:0] rsp_start_offset;
   logic [7:0]  rsp_token_length;
   logic        rsp_last_of_run;

   always #5 clock = ~clock;

   source_code_lexer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ch           (req_ch),
      .req_end_of_source(req_end_of_source),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_line   (rsp_start_line),
      .rsp_start_col    (rsp_start_col),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   // one source beat; chk marks rows whose final token is typed in by hand
   typedef struct packed {
      logic [7:0] ch;
      logic       eos;
      logic       chk;
      logic [6:0] kind;
      logic [7:0] len;
   } src_beat_type;

   typedef struct {
      logic [6:0]  kind;
      logic [15:0] line;
      logic [15:0] col;
      logic [31:0] offset;
      logic [7:0]  length;
      logic        last;
   } lex_token_type;

   // Directed rows: EOF right after reset, keyword "if", ">>=", a number cut by a
   // second dot (dot lexed fresh, two tokens in one beat), "7f" closed by its suffix,
   // byte extremes as undefined tokens, a newline, and EOF flushing a pending "%".
   localparam int DIR_ROWS = 20;
   localparam src_beat_type DIR_TAB [DIR_ROWS] = '{
      '{8'h00, 1'b1, 1'b1, scl_pkg::K_EOF,    8'd3},
      '{"i",   1'b0, 1'b0, 7'd0,              8'd0},
      '{"f",   1'b0, 1'b0, 7'd0,              8'd0},
      '{" ",   1'b0, 1'b1, KW_IF,             8'd2},
      '{">",   1'b0, 1'b0, 7'd0,              8'd0},
      '{">",   1'b0, 1'b0, 7'd0,              8'd0},
      '{"=",   1'b0, 1'b1, scl_pkg::K_SHREQ,  8'd3},
      '{"1",   1'b0, 1'b0, 7'd0,              8'd0},
      '{".",   1'b0, 1'b0, 7'd0,              8'd0},
      '{"5",   1'b0, 1'b0, 7'd0,              8'd0},
      '{".",   1'b0, 1'b1, scl_pkg::K_DOT,    8'd1},
      '{"7",   1'b0, 1'b0, 7'd0,              8'd0},
      '{"f",   1'b0, 1'b1, scl_pkg::K_NUMBER, 8'd2},
      '{8'h00, 1'b0, 1'b1, scl_pkg::K_UNDEF,  8'd1},
      '{8'hFF, 1'b0, 1'b1, scl_pkg::K_UNDEF,  8'd1},
      '{8'h80, 1'b0, 1'b1, scl_pkg::K_UNDEF,  8'd1},
      '{8'h0A, 1'b0, 1'b0, 7'd0,              8'd0},
      '{"x",   1'b0, 1'b0, 7'd0,              8'd0},
      '{"%",   1'b0, 1'b0, 7'd0,              8'd0},
      '{8'h55, 1'b1, 1'b1, scl_pkg::K_EOF,    8'd3}
   };

   string kw_names [34] = '{"int", "int8", "int16", "int32", "int64", "uint8", "uint16",
      "uint32", "uint64", "bool", "true", "false", "float", "double", "char", "utf8char",
      "utf16char", "void", "if", "do", "for", "big", "continue", "return", "break",
      "while", "switch", "case", "small", "enum", "typedefinition", "else", "struct",
      "static"};
   string op_names [20] = '{">>=", "<<=", "&&", "||", "++", "--", "+=", "-=", "*=", "/=",
      "%=", "&=", "|=", "==", ">=", "<=", ">>", "<<", ";", "."};

   src_beat_type   beats [$];
   lex_token_type  token_fifo [$];
   bit             failed = 1'b0;
   bit             quiet = 1'b0;      // no idling in the closing stretch
   bit             long_hold = 1'b0;  // request for one long receiver hold-off
   src_beat_type   cur_beat;

   // ---------------- lexer model state ----------------
   scl_pkg::mode_type lx_mode;
   bit             lx_dot;
   bit [33:0]      lx_cand;
   int unsigned    lx_plen, lx_pline, lx_pcol, lx_poff;
   int unsigned    lx_line, lx_col, lx_off;
   lex_token_type  beat_toks [$];

   function automatic bit char_is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic bit char_is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   task automatic lexer_clear();
      lx_mode = scl_pkg::M_IDLE;
      lx_dot = 1'b0;
      lx_cand = '1;
      lx_plen = 0;
      lx_pline = 1;
      lx_pcol = 1;
      lx_poff = 0;
      lx_line = 1;
      lx_col = 1;
      lx_off = 0;
   endtask

   task automatic emit(logic [6:0] kind, int unsigned line, int unsigned col,
                       int unsigned off, int unsigned len);
      lex_token_type t;
      t.kind = kind;
      t.line = line[15:0];
      t.col = col[15:0];
      t.offset = off;
      t.length = len[7:0];
      t.last = 1'b0;
      beat_toks.push_back(t);
   endtask

   task automatic emit_pending(logic [6:0] kind, int unsigned len);
      lx_mode = scl_pkg::M_IDLE;
      emit(kind, lx_pline, lx_pcol, lx_poff, len);
   endtask

   // drop keywords that disagree with character c at the current position
   task automatic narrow(logic [7:0] c);
      for (int k = 0; k < 34; k++) begin
         if (lx_cand[k]) begin
            if (lx_plen >= kw_names[k].len()) lx_cand[k] = 1'b0;
            else if (kw_names[k][lx_plen] != c) lx_cand[k] = 1'b0;
         end
      end
   endtask

   task automatic close_pending();
      logic [6:0] kind;
      case (lx_mode)
         scl_pkg::M_IDLE: ;
         scl_pkg::M_IDENT: begin
            kind = scl_pkg::K_IDENT;
            for (int k = 0; k < 34; k++) begin
               if (kind == scl_pkg::K_IDENT && lx_cand[k] && lx_plen == kw_names[k].len())
                  kind = k[6:0];
            end
            emit_pending(kind, lx_plen);
         end
         scl_pkg::M_NUM:   emit_pending(scl_pkg::K_NUMBER, lx_plen);
         scl_pkg::M_GTGT:  emit_pending(scl_pkg::K_SHR, 2);
         scl_pkg::M_LTLT:  emit_pending(scl_pkg::K_SHL, 2);
         scl_pkg::M_EQ:    emit_pending(scl_pkg::K_EQ, 1);
         scl_pkg::M_PLUS:  emit_pending(scl_pkg::K_PLUS, 1);
         scl_pkg::M_MINUS: emit_pending(scl_pkg::K_MINUS, 1);
         scl_pkg::M_GT:    emit_pending(scl_pkg::K_GT, 1);
         scl_pkg::M_LT:    emit_pending(scl_pkg::K_LT, 1);
         scl_pkg::M_STAR:  emit_pending(scl_pkg::K_STAR, 1);
         scl_pkg::M_SLASH: emit_pending(scl_pkg::K_SLASH, 1);
         scl_pkg::M_AMP:   emit_pending(scl_pkg::K_AMP, 1);
         scl_pkg::M_PIPE:  emit_pending(scl_pkg::K_PIPE, 1);
         default:          emit_pending(scl_pkg::K_PCT, 1);
      endcase
   endtask

   task automatic start_token(scl_pkg::mode_type m);
      lx_mode = m;
      lx_pline = lx_line;
      lx_pcol = lx_col;
      lx_poff = lx_off;
      lx_plen = 1;
   endtask

   // byte with nothing pending
   task automatic lex_fresh(logic [7:0] c);
      logic [6:0] kind;
      kind = scl_pkg::K_UNDEF;
      if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) return;
      if (char_is_letter(c)) begin
         lx_cand = '1;
         lx_plen = 0;
         narrow(c);
         start_token(scl_pkg::M_IDENT);
         return;
      end
      if (char_is_num(c)) begin
         lx_dot = 1'b0;
         start_token(scl_pkg::M_NUM);
         return;
      end
      case (c)
         "=": begin start_token(scl_pkg::M_EQ); return; end
         "+": begin start_token(scl_pkg::M_PLUS); return; end
         "-": begin start_token(scl_pkg::M_MINUS); return; end
         ">": begin start_token(scl_pkg::M_GT); return; end
         "<": begin start_token(scl_pkg::M_LT); return; end
         "*": begin start_token(scl_pkg::M_STAR); return; end
         "/": begin start_token(scl_pkg::M_SLASH); return; end
         "&": begin start_token(scl_pkg::M_AMP); return; end
         "|": begin start_token(scl_pkg::M_PIPE); return; end
         "%": begin start_token(scl_pkg::M_PCT); return; end
         ";": kind = scl_pkg::K_SEMI;
         "(": kind = scl_pkg::K_LPAREN;
         ")": kind = scl_pkg::K_RPAREN;
         "{": kind = scl_pkg::K_LBRACE;
         "}": kind = scl_pkg::K_RBRACE;
         "[": kind = scl_pkg::K_LBRACK;
         "]": kind = scl_pkg::K_RBRACK;
         ":": kind = scl_pkg::K_COLON;
         ".": kind = scl_pkg::K_DOT;
         "?": kind = scl_pkg::K_QUEST;
         ",": kind = scl_pkg::K_COMMA;
         default: kind = scl_pkg::K_UNDEF;
      endcase
      emit(kind, lx_line, lx_col, lx_off, 1);
   endtask

   // two- or three-character operator finished by c; 0 when none
   function automatic logic [6:0] op_finish(scl_pkg::mode_type m, logic [7:0] c);
      case (m)
         scl_pkg::M_EQ:    return c == "=" ? scl_pkg::K_EQEQ : 7'd0;
         scl_pkg::M_PLUS:  return c == "=" ? scl_pkg::K_PLUSEQ :
                                  (c == "+" ? scl_pkg::K_INC : 7'd0);
         scl_pkg::M_MINUS: return c == "-" ? scl_pkg::K_DEC :
                                  (c == "=" ? scl_pkg::K_MINUSEQ : 7'd0);
         scl_pkg::M_GT:    return c == "=" ? scl_pkg::K_GE : 7'd0;
         scl_pkg::M_GTGT:  return c == "=" ? scl_pkg::K_SHREQ : 7'd0;
         scl_pkg::M_LT:    return c == "=" ? scl_pkg::K_LE : 7'd0;
         scl_pkg::M_LTLT:  return c == "=" ? scl_pkg::K_SHLEQ : 7'd0;
         scl_pkg::M_STAR:  return c == "=" ? scl_pkg::K_STAREQ : 7'd0;
         scl_pkg::M_SLASH: return c == "=" ? scl_pkg::K_SLASHEQ : 7'd0;
         scl_pkg::M_AMP:   return c == "&" ? scl_pkg::K_ANDAND :
                                  (c == "=" ? scl_pkg::K_ANDEQ : 7'd0);
         scl_pkg::M_PIPE:  return c == "|" ? scl_pkg::K_OROR :
                                  (c == "=" ? scl_pkg::K_OREQ : 7'd0);
         scl_pkg::M_PCT:   return c == "=" ? scl_pkg::K_PCTEQ : 7'd0;
         default:          return 7'd0;
      endcase
   endfunction

   task automatic lex_char(logic [7:0] c);
      logic [6:0] kind;
      if (lx_mode == scl_pkg::M_IDENT) begin
         if (char_is_letter(c) || char_is_num(c)) begin
            narrow(c);
            if (lx_plen < 255) lx_plen++;
            return;
         end
      end else if (lx_mode == scl_pkg::M_NUM) begin
         if (char_is_num(c) || (c == "." && !lx_dot)) begin
            if (c == ".") lx_dot = 1'b1;
            if (lx_plen < 255) lx_plen++;
            return;
         end
         if (c == "f") begin
            if (lx_plen < 255) lx_plen++;
            emit_pending(scl_pkg::K_NUMBER, lx_plen);
            return;
         end
      end else if (lx_mode == scl_pkg::M_GT && c == ">") begin
         lx_mode = scl_pkg::M_GTGT;
         return;
      end else if (lx_mode == scl_pkg::M_LT && c == "<") begin
         lx_mode = scl_pkg::M_LTLT;
         return;
      end else if (lx_mode != scl_pkg::M_IDLE) begin
         kind = op_finish(lx_mode, c);
         if (kind != 7'd0) begin
            emit_pending(kind, (lx_mode == scl_pkg::M_GTGT ||
                                lx_mode == scl_pkg::M_LTLT) ? 3 : 2);
            return;
         end
      end
      close_pending();
      lex_fresh(c);
   endtask

   // tokens caused by one accepted beat, appended to token_fifo
   task automatic lex_beat(logic [7:0] c, logic eos);
      beat_toks.delete();
      if (eos) begin
         close_pending();
         emit(scl_pkg::K_EOF, lx_line, lx_col, lx_off, 3);
         lexer_clear();
      end else begin
         lex_char(c);
         if (lx_off != 32'hFFFF_FFFF) lx_off++;
         if (c == 8'h0A) begin
            if (lx_line < 16'hFFFF) lx_line++;
            lx_col = 1;
         end else if (lx_col < 16'hFFFF) begin
            lx_col++;
         end
      end
      if (beat_toks.size() > 0) beat_toks[beat_toks.size() - 1].last = 1'b1;
      foreach (beat_toks[i]) token_fifo.push_back(beat_toks[i]);
   endtask

   // ---------------- stimulus building ----------------
   function automatic void put_byte(logic [7:0] c);
      src_beat_type b;
      b = '0;
      b.ch = c;
      beats.push_back(b);
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endfunction

   function automatic void put_eos();
      src_beat_type b;
      b = '0;
      b.ch = 8'($urandom_range(0, 255));
      b.eos = 1'b1;
      beats.push_back(b);
   endfunction

   function automatic void put_ident(int n);
      string alnum;
      alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      put_byte(alnum[$urandom_range(0, 52)]);
      for (int i = 1; i < n; i++) put_byte(alnum[$urandom_range(0, 62)]);
   endfunction

   function automatic void put_number();
      int n;
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) put_byte(8'("0" + $urandom_range(0, 9)));
      if ($urandom_range(0, 2) == 0) begin
         put_byte(".");
         for (int i = 0; i < $urandom_range(0, 3); i++)
            put_byte(8'("0" + $urandom_range(0, 9)));
      end
      if ($urandom_range(0, 3) == 0) put_byte("f");
   endfunction

   function automatic void put_gap();
      case ($urandom_range(0, 7))
         0, 1, 2: put_byte(" ");
         3: put_byte(8'h0A);
         4: put_byte(8'h09);
         5: put_byte(8'h0D);
         default: ;  // tokens abut, maximal munch decides
      endcase
   endfunction

   function automatic void build_random();
      int r;
      int p;
      bit long_done;
      string punct;
      long_done = 1'b0;
      punct = "-+=><*/&|%(){}[]:?,;!";
      while (beats.size() < DIR_ROWS + 1050) begin
         r = $urandom_range(0, 99);
         if (r < 25) put_text(kw_names[$urandom_range(0, 33)]);
         else if (r < 40) put_ident($urandom_range(1, 10));
         else if (r < 55) put_number();
         else if (r < 75) put_text(op_names[$urandom_range(0, 19)]);
         else if (r < 80) begin
            p = $urandom_range(0, 20);
            put_byte(punct[p]);
         end
         else if (r < 92) put_byte(8'($urandom_range(0, 255)));
         else if (r < 96) put_eos();
         else if (!long_done && beats.size() > 500) begin
            // identifier longer than the length counter can hold
            put_ident(300);
            long_done = 1'b1;
         end
         put_gap();
      end
      put_eos();
   endfunction

   // ---------------- receiver ----------------
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (long_hold) begin
         // sender keeps offering beats while the output queue fills
         long_hold = 1'b0;
         stall_left = 150;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 12);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------- prediction and checking ----------------
   int idle_cycles = 0;
   always @(posedge clock) begin
      lex_token_type e;
      if (!reset) begin
         if (req_valid && req_ready) begin
            lex_beat(req_ch, req_end_of_source);
            if (cur_beat.chk) begin
               e = beat_toks[beat_toks.size() - 1];
               if (e.kind !== cur_beat.kind || e.length !== cur_beat.len) begin
                  $display("%0t: table row mismatch kind/len expected %0d/%0d actual %0d/%0d",
                           $time, cur_beat.kind, cur_beat.len, e.kind, e.length);
                  failed = 1'b1;
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (token_fifo.size() == 0) begin
               $display("%0t: unexpected token kind %0d", $time, rsp_token_kind);
               failed = 1'b1;
            end else begin
               e = token_fifo.pop_front();
               if (rsp_token_kind !== e.kind) begin
                  $display("%0t: kind expected %0d actual %0d", $time, e.kind, rsp_token_kind);
                  failed = 1'b1;
               end
               if (rsp_start_line !== e.line) begin
                  $display("%0t: line expected %0d actual %0d", $time, e.line, rsp_start_line);
                  failed = 1'b1;
               end
               if (rsp_start_col !== e.col) begin
                  $display("%0t: col expected %0d actual %0d", $time, e.col, rsp_start_col);
                  failed = 1'b1;
               end
               if (rsp_start_offset !== e.offset) begin
                  $display("%0t: offset expected %0d actual %0d", $time, e.offset,
                           rsp_start_offset);
                  failed = 1'b1;
               end
               if (rsp_token_length !== e.length) begin
                  $display("%0t: length expected %0d actual %0d", $time, e.length,
                           rsp_token_length);
                  failed = 1'b1;
               end
               if (rsp_last_of_run !== e.last) begin
                  $display("%0t: last expected %0d actual %0d", $time, e.last,
                           rsp_last_of_run);
                  failed = 1'b1;
               end
            end
         end
      end
      // watchdog: cycles with no beat on either channel
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------- sender and end of run ----------------
   initial begin
      int gap;
      lexer_clear();
      cur_beat = '0;
      for (int i = 0; i < DIR_ROWS; i++) beats.push_back(DIR_TAB[i]);
      build_random();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < beats.size(); i++) begin
         if (i == beats.size() - 120) quiet = 1'b1;
         if (i == 400) long_hold = 1'b1;
         if (i == 700) begin
            // drain completely before going on
            req_valid <= 1'b0;
            @(posedge clock);
            while (token_fifo.size() != 0) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_ch <= beats[i].ch;
         req_end_of_source <= beats[i].eos;
         cur_beat <= beats[i];
         @(posedge clock);
         while (!req_ready) @(posedge clock);
      end
      req_valid <= 1'b0;
      while (token_fifo.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (!failed && token_fifo.size() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
